### sv/lfpd_pkg.sv
// Shared types and constants of the line follower PD steering block.
`timescale 1ns / 1ps
`default_nettype none
package lfpd_pkg;

  // Register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int GAIN_W     = 12;
  localparam int SPEED_W    = 8;
  localparam int LIMIT_W    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_DERIV_GAIN   = 3'd1,
    CFG_CRUISE_SPEED = 3'd2,
    CFG_TURN_SPEED   = 3'd3,
    CFG_DEADBAND     = 3'd4,
    CFG_EDGE_LIMIT   = 3'd5,
    CFG_CENTER_LIMIT = 3'd6
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 12'd461;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 12'd589;
  localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 8'd0;
  localparam logic [SPEED_W-1:0] RST_TURN_SPEED   = 8'd150;
  localparam logic [SPEED_W-1:0] RST_DEADBAND     = 8'd50;
  localparam logic [LIMIT_W-1:0] RST_EDGE_LIMIT   = 10'd700;
  localparam logic [LIMIT_W-1:0] RST_CENTER_LIMIT = 10'd400;

  // Sensor pair lanes
  localparam int LANE_COUNT = 4;
  localparam int WEIGHT_W   = 3;

  // Scaling by 255 / (10000 * 256) = 255 / (1024 * 2500)
  localparam int SCALE_NUM_SHIFT = 8;      // x * 255 = (x << 8) - x
  localparam int SCALE_SHIFT     = 10;     // first divide by 1024
  localparam int N_W             = 20;
  localparam logic [N_W-1:0] N_SAT = 20'd640000; // 256 * 2500, quotient saturates at 256
  localparam int RECIP_W         = 21;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1717987; // ceil(2^32 / 2500)
  localparam int RECIP_SHIFT     = 32;
  localparam int PROD_W          = N_W + RECIP_W;
  localparam int Q_W             = 9;
  localparam logic [Q_W-1:0] Q_SAT = 9'd256;
  localparam logic [SPEED_W-1:0] DUTY_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic sum;
    logic mul;
    logic scale;
    logic div;
  } stage_en_t;

endpackage
`default_nettype wire

### sv/lfpd_sensor_if.sv
// Sensor item channel: eight averaged readings with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface lfpd_sensor_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sensor_0;
  logic [SAMPLE_BITS-1:0] sensor_1;
  logic [SAMPLE_BITS-1:0] sensor_2;
  logic [SAMPLE_BITS-1:0] sensor_3;
  logic [SAMPLE_BITS-1:0] sensor_4;
  logic [SAMPLE_BITS-1:0] sensor_5;
  logic [SAMPLE_BITS-1:0] sensor_6;
  logic [SAMPLE_BITS-1:0] sensor_7;

  modport source (
    output valid, sensor_0, sensor_1, sensor_2, sensor_3,
           sensor_4, sensor_5, sensor_6, sensor_7,
    input  ready
  );
  modport sink (
    input  valid, sensor_0, sensor_1, sensor_2, sensor_3,
           sensor_4, sensor_5, sensor_6, sensor_7,
    output ready
  );
endinterface
`default_nettype wire

### sv/lfpd_result_if.sv
// Result item channel: motor duty and directions with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface lfpd_result_if;
  logic                            valid;
  logic                            ready;
  logic [lfpd_pkg::SPEED_W-1:0]    duty;
  logic                            left_reverse;
  logic                            right_reverse;

  modport source (
    output valid, duty, left_reverse, right_reverse,
    input  ready
  );
  modport sink (
    input  valid, duty, left_reverse, right_reverse,
    output ready
  );
endinterface
`default_nettype wire

### sv/lfpd_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface lfpd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lfpd_pkg::CFG_IDX_W-1:0]    index;
  logic [lfpd_pkg::CFG_DATA_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface
`default_nettype wire

### sv/lfpd_lane.sv
// One sensor pair lane: weighted right minus left difference.
`timescale 1ns / 1ps
`default_nettype none
module lfpd_lane #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [SAMPLE_BITS-1:0]              left_i,
  input  logic [SAMPLE_BITS-1:0]              right_i,
  input  logic [lfpd_pkg::WEIGHT_W-1:0]       weight_i,
  output logic signed [SAMPLE_BITS+2:0]       prod_o
);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int LANE_W = SAMPLE_BITS + 3;

  logic signed [DIFF_W-1:0] diff;
  logic signed [LANE_W-1:0] diff_ext;
  logic signed [LANE_W-1:0] weight_ext;
  logic signed [LANE_W-1:0] prod_d;
  logic signed [LANE_W-1:0] prod_q;

  assign diff       = $signed({1'b0, right_i}) - $signed({1'b0, left_i});
  assign diff_ext   = LANE_W'(diff);
  assign weight_ext = LANE_W'($signed({1'b0, weight_i}));
  assign prod_d     = diff_ext * weight_ext;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

### sv/lfpd_merge.sv
// Merge stage: sum of the four lane products into the line error.
`timescale 1ns / 1ps
`default_nettype none
module lfpd_merge #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                       clk_i,
  input  lfpd_pkg::stage_en_t        en_i,
  input  logic signed [SAMPLE_BITS+2:0] lane_i [lfpd_pkg::LANE_COUNT],
  output logic signed [SAMPLE_BITS+4:0] err_o
);
  localparam int ERR_W = SAMPLE_BITS + 5;

  logic signed [ERR_W-1:0] sum_lo;
  logic signed [ERR_W-1:0] sum_hi;
  logic signed [ERR_W-1:0] err_q;

  assign sum_lo = ERR_W'(lane_i[0]) + ERR_W'(lane_i[1]);
  assign sum_hi = ERR_W'(lane_i[2]) + ERR_W'(lane_i[3]);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      err_q <= sum_lo + sum_hi;
    end
  end

  assign err_o = err_q;
endmodule
`default_nettype wire

### sv/lfpd_pd.sv
// PD term: gain products, scaling by 255/2560000 and reciprocal divide.
`timescale 1ns / 1ps
`default_nettype none
module lfpd_pd #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfpd_pkg::stage_en_t               en_i,
  input  logic signed [SAMPLE_BITS+4:0]     err_i,
  input  logic [lfpd_pkg::GAIN_W-1:0]       prop_gain_i,
  input  logic [lfpd_pkg::GAIN_W-1:0]       deriv_gain_i,
  output logic [lfpd_pkg::Q_W-1:0]          q_o,
  output logic                              neg_o
);
  localparam int ERR_W  = SAMPLE_BITS + 5;
  localparam int DIFF_W = ERR_W + 1;
  localparam int P_W    = ERR_W + lfpd_pkg::GAIN_W + 1;
  localparam int D_W    = DIFF_W + lfpd_pkg::GAIN_W + 1;
  localparam int ACC_W  = D_W + 1;
  localparam int M_W    = ACC_W + lfpd_pkg::SCALE_NUM_SHIFT;
  localparam int NF_W   = M_W - lfpd_pkg::SCALE_SHIFT;

  logic signed [ERR_W-1:0]  prev_q;
  logic signed [DIFF_W-1:0] diff;
  logic signed [P_W-1:0]    p_d, p_q;
  logic signed [D_W-1:0]    d_d, d_q;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         mag;
  logic [M_W-1:0]           mag_ext;
  logic [M_W-1:0]           m;
  logic [NF_W-1:0]          n_full;
  logic [lfpd_pkg::N_W-1:0] n_d, n_q;
  logic                     neg_q;
  logic [lfpd_pkg::PROD_W-1:0] prod;
  logic [lfpd_pkg::Q_W-1:0] q_q;

  // Gain products
  assign diff = DIFF_W'(err_i) - DIFF_W'(prev_q);
  assign p_d  = P_W'($signed({1'b0, prop_gain_i})) * P_W'(err_i);
  assign d_d  = D_W'($signed({1'b0, deriv_gain_i})) * D_W'(diff);

  // Magnitude times 255, divided by 1024, clamped where the quotient reaches 256
  assign acc     = ACC_W'(p_q) + ACC_W'(d_q);
  assign mag     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign mag_ext = M_W'(mag);
  assign m       = (mag_ext << lfpd_pkg::SCALE_NUM_SHIFT) - mag_ext;
  assign n_full  = m[M_W-1:lfpd_pkg::SCALE_SHIFT];

  always_comb begin
    if (n_full >= NF_W'(lfpd_pkg::N_SAT)) begin
      n_d = lfpd_pkg::N_SAT;
    end else begin
      n_d = n_full[lfpd_pkg::N_W-1:0];
    end
  end

  // Exact divide by 2500 over the clamped range
  assign prod = lfpd_pkg::PROD_W'(n_q) * lfpd_pkg::PROD_W'(lfpd_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (en_i.mul) begin
      prev_q <= err_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      p_q <= p_d;
      d_q <= d_d;
    end
    if (en_i.scale) begin
      n_q   <= n_d;
      neg_q <= acc[ACC_W-1];
    end
    if (en_i.div) begin
      q_q <= prod[lfpd_pkg::RECIP_SHIFT +: lfpd_pkg::Q_W];
    end
  end

  assign q_o   = q_q;
  assign neg_o = neg_q;

`ifndef SYNTHESIS
  a_prev_tracks_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i.mul |=> prev_q == $past(err_i))
    else $error("previous error not updated from the current error");

  a_n_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i.scale |=> n_q <= lfpd_pkg::N_SAT)
    else $error("scaled magnitude above clamp");

  a_q_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i.div |=> q_q <= lfpd_pkg::Q_SAT)
    else $error("quotient above saturation value");
`endif
endmodule
`default_nettype wire

### sv/line_follower_pd_steering_unit.sv
// Top level of the line follower PD steering block.
//
//  Channel  Dir  Handshake    Carries
//  sens_i   in   valid/ready  sensor_0 .. sensor_7, SAMPLE_BITS each
//  res_o    out  valid/ready  duty, left_reverse, right_reverse
//  cfg_i    in   valid/ready  index, data (register write, always ready)
//
// One item at a time: the accept edge loads the four pair lanes, then the merge,
// gain product, scaling, reciprocal divide and decision steps run in that order,
// the decision step loading the output register, and the next item is taken only
// once the sequencer is back in idle after the decision step.
// Reset clears the registers to their defaults, the previous error and last turn.
// A result that waits in the output register holds back the decision step and so also the next item.
`timescale 1ns / 1ps
`default_nettype none
module line_follower_pd_steering_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfpd_sensor_if.sink   sens_i,
  lfpd_result_if.source res_o,
  lfpd_cfg_if.sink      cfg_i
);
  localparam int LANE_W = SAMPLE_BITS + 3;
  localparam int ERR_W  = SAMPLE_BITS + 5;
  localparam int CMP_W  = (SAMPLE_BITS > lfpd_pkg::LIMIT_W) ? SAMPLE_BITS : lfpd_pkg::LIMIT_W;

  // Configuration registers
  logic [lfpd_pkg::GAIN_W-1:0]  prop_gain_q;
  logic [lfpd_pkg::GAIN_W-1:0]  deriv_gain_q;
  logic [lfpd_pkg::SPEED_W-1:0] cruise_speed_q;
  logic [lfpd_pkg::SPEED_W-1:0] turn_speed_q;
  logic [lfpd_pkg::SPEED_W-1:0] deadband_q;
  logic [lfpd_pkg::LIMIT_W-1:0] edge_limit_q;
  logic [lfpd_pkg::LIMIT_W-1:0] center_limit_q;

  logic cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  // Take a write at any time; unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= lfpd_pkg::RST_PROP_GAIN;
      deriv_gain_q   <= lfpd_pkg::RST_DERIV_GAIN;
      cruise_speed_q <= lfpd_pkg::RST_CRUISE_SPEED;
      turn_speed_q   <= lfpd_pkg::RST_TURN_SPEED;
      deadband_q     <= lfpd_pkg::RST_DEADBAND;
      edge_limit_q   <= lfpd_pkg::RST_EDGE_LIMIT;
      center_limit_q <= lfpd_pkg::RST_CENTER_LIMIT;
    end else if (cfg_wr) begin
      case (lfpd_pkg::cfg_idx_e'(cfg_i.index))
        lfpd_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_i.data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_i.data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_CRUISE_SPEED: cruise_speed_q <= cfg_i.data[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::CFG_TURN_SPEED:   turn_speed_q   <= cfg_i.data[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::CFG_DEADBAND:     deadband_q     <= cfg_i.data[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::CFG_EDGE_LIMIT:   edge_limit_q   <= cfg_i.data[lfpd_pkg::LIMIT_W-1:0];
        lfpd_pkg::CFG_CENTER_LIMIT: center_limit_q <= cfg_i.data[lfpd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and stage enables
  lfpd_pkg::state_e    state_q, state_d;
  lfpd_pkg::stage_en_t stage_en;
  logic                sens_acc;
  logic                res_load;

  assign sens_acc = sens_i.valid && sens_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic out_valid_q;

  always_comb begin
    state_d      = state_q;
    sens_i.ready = 1'b0;
    stage_en     = '0;
    res_load     = 1'b0;
    case (state_q)
      lfpd_pkg::ST_IDLE: begin
        sens_i.ready = 1'b1;
        if (sens_i.valid) begin
          state_d = lfpd_pkg::ST_SUM;
        end
      end
      lfpd_pkg::ST_SUM: begin
        stage_en.sum = 1'b1;
        state_d      = lfpd_pkg::ST_MUL;
      end
      lfpd_pkg::ST_MUL: begin
        stage_en.mul = 1'b1;
        state_d      = lfpd_pkg::ST_SCALE;
      end
      lfpd_pkg::ST_SCALE: begin
        stage_en.scale = 1'b1;
        state_d        = lfpd_pkg::ST_DIV;
      end
      lfpd_pkg::ST_DIV: begin
        stage_en.div = 1'b1;
        state_d      = lfpd_pkg::ST_DONE;
      end
      lfpd_pkg::ST_DONE: begin
        // Hold here until the output register is free or draining.
        if (!out_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = lfpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfpd_pkg::ST_IDLE;
      end
    endcase
  end

  // Pair lanes: lane i weighs sensor (7-i) minus sensor i by 4-i
  logic [SAMPLE_BITS-1:0]   sample [8];
  logic signed [LANE_W-1:0] lane_prod [lfpd_pkg::LANE_COUNT];

  assign sample[0] = sens_i.sensor_0;
  assign sample[1] = sens_i.sensor_1;
  assign sample[2] = sens_i.sensor_2;
  assign sample[3] = sens_i.sensor_3;
  assign sample[4] = sens_i.sensor_4;
  assign sample[5] = sens_i.sensor_5;
  assign sample[6] = sens_i.sensor_6;
  assign sample[7] = sens_i.sensor_7;

  for (genvar g = 0; g < lfpd_pkg::LANE_COUNT; g++) begin : g_lane
    lfpd_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .load_i  (sens_acc),
      .left_i  (sample[g]),
      .right_i (sample[7-g]),
      .weight_i(lfpd_pkg::WEIGHT_W'(lfpd_pkg::LANE_COUNT - g)),
      .prod_o  (lane_prod[g])
    );
  end

  // Centered-on-line check, captured with the item
  logic online_q;

  always_ff @(posedge clk_i) begin
    if (sens_acc) begin
      online_q <= (CMP_W'(sample[7]) < CMP_W'(edge_limit_q))   &&
                  (CMP_W'(sample[0]) < CMP_W'(edge_limit_q))   &&
                  (CMP_W'(sample[3]) > CMP_W'(center_limit_q)) &&
                  (CMP_W'(sample[4]) > CMP_W'(center_limit_q));
    end
  end

  logic signed [ERR_W-1:0] err;

  lfpd_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .lane_i(lane_prod),
    .err_o (err)
  );

  logic [lfpd_pkg::Q_W-1:0] term_mag;
  logic                     term_neg;

  lfpd_pd #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (stage_en),
    .err_i       (err),
    .prop_gain_i (prop_gain_q),
    .deriv_gain_i(deriv_gain_q),
    .q_o         (term_mag),
    .neg_o       (term_neg)
  );

  // Decision: steer outside the deadband, cruise when centered, else search
  logic                         last_turn_q;
  logic [lfpd_pkg::SPEED_W-1:0] duty_d;
  logic                         left_d, right_d;
  logic                         steer;
  logic [lfpd_pkg::SPEED_W-1:0] term_duty;

  assign steer     = term_mag > lfpd_pkg::Q_W'(deadband_q);
  assign term_duty = term_mag[lfpd_pkg::Q_W-1] ? lfpd_pkg::DUTY_MAX
                                               : term_mag[lfpd_pkg::SPEED_W-1:0];

  always_comb begin
    if (steer) begin
      duty_d  = term_duty;
      left_d  = term_neg;
      right_d = !term_neg;
    end else if (online_q) begin
      duty_d  = cruise_speed_q;
      left_d  = 1'b0;
      right_d = 1'b0;
    end else begin
      duty_d  = turn_speed_q;
      left_d  = last_turn_q;
      right_d = !last_turn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_turn_q <= 1'b0;
    end else if (res_load && steer) begin
      last_turn_q <= term_neg;
    end
  end

  // Output register
  logic [lfpd_pkg::SPEED_W-1:0] out_duty_q;
  logic                         out_left_q, out_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_duty_q  <= duty_d;
      out_left_q  <= left_d;
      out_right_q <= right_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.duty          = out_duty_q;
  assign res_o.left_reverse  = out_left_q;
  assign res_o.right_reverse = out_right_q;

`ifndef SYNTHESIS
  a_no_double_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_left_q && out_right_q))
    else $error("both motors reversed");

  a_stall_holds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfpd_pkg::ST_DONE && out_valid_q && !res_o.ready)
      |=> state_q == lfpd_pkg::ST_DONE)
    else $error("decision step left while output stalled");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == lfpd_pkg::ST_DONE)
    else $error("result shown without a finished item");
`endif
endmodule
`default_nettype wire
